// ===== src/bb3_pkg.sv =====
package bb3_pkg;

	// restoring divide steps for a 13-bit dividend (2*sum + count)
	localparam int DIV_STEPS = 13;
	localparam int NUM_W = 13;
	localparam int SUM_W = 12;
	localparam int CNT_W = 4;
	localparam int DEN_W = 5;
	localparam int PIX_W = 24;
	localparam int NBANK = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_DRAIN,
		ST_DLOAD,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       wr_en;
		logic [1:0] wr_bank;
		logic       acc_clr;
		logic       rd_en;
		logic       col_ok;
		logic [2:0] bank_mask;
		logic       div_load;
		logic       div_step;
		logic       out_load;
		logic       run_last;
		logic       frame_end;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

// ===== src/bb3_ram.sv =====
module bb3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/bb3_dp.sv =====
module bb3_dp #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bb3_pkg::dp_cmd_t             cmd,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic [23:0]                  pix_in,
	output bb3_pkg::dp_stat_t            stat,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,
	output logic                         m_tlast,
	output logic                         m_tuser
);

	logic [bb3_pkg::PIX_W-1:0] rdata [bb3_pkg::NBANK];

	for (genvar b = 0; b < bb3_pkg::NBANK; b++) begin : g_bank
		bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
			.clk   (clk),
			.we    (cmd.wr_en && (cmd.wr_bank == 2'(b))),
			.waddr (wr_addr),
			.wdata (pix_in),
			.re    (cmd.rd_en),
			.raddr (rd_addr),
			.rdata (rdata[b])
		);
	end

	logic       acc_s1;
	logic [2:0] mask_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1  <= 1'b0;
			mask_s1 <= '0;
		end else begin
			acc_s1  <= cmd.rd_en & cmd.col_ok;
			mask_s1 <= cmd.bank_mask;
		end
	end

	logic [2:0][bb3_pkg::SUM_W-1:0] sum_q;
	logic [2:0][bb3_pkg::SUM_W-1:0] add;
	logic [bb3_pkg::CNT_W-1:0]      cnt_q;
	logic [bb3_pkg::CNT_W-1:0]      cnt_add;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			add[ch] = '0;
			for (int b = 0; b < bb3_pkg::NBANK; b++) begin
				if (mask_s1[b]) begin
					add[ch] = add[ch] + bb3_pkg::SUM_W'(rdata[b][8*ch +: 8]);
				end
			end
		end
		cnt_add = bb3_pkg::CNT_W'(mask_s1[0]) + bb3_pkg::CNT_W'(mask_s1[1])
			+ bb3_pkg::CNT_W'(mask_s1[2]);
	end

	logic [2:0][bb3_pkg::NUM_W-1:0] num_q;
	logic [2:0][bb3_pkg::DEN_W-1:0] rem_q;
	logic [bb3_pkg::DEN_W-1:0]      den_q;
	logic [bb3_pkg::CNT_W-1:0]      cnt_g;

	assign cnt_g = (cnt_q == '0) ? bb3_pkg::CNT_W'(1) : cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (acc_s1) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum_q[ch] <= sum_q[ch] + add[ch];
			end
			cnt_q <= cnt_q + cnt_add;
		end

		if (cmd.div_load) begin
			for (int ch = 0; ch < 3; ch++) begin
				num_q[ch] <= {sum_q[ch], 1'b0} + bb3_pkg::NUM_W'(cnt_g);
				rem_q[ch] <= '0;
			end
			den_q <= {cnt_g, 1'b0};
		end else if (cmd.div_step) begin
			for (int ch = 0; ch < 3; ch++) begin
				logic [bb3_pkg::DEN_W:0] t;
				logic                    ge;
				t  = {rem_q[ch], num_q[ch][bb3_pkg::NUM_W-1]};
				ge = t >= {1'b0, den_q};
				rem_q[ch] <= ge ? bb3_pkg::DEN_W'(t - {1'b0, den_q})
					: bb3_pkg::DEN_W'(t);
				num_q[ch] <= {num_q[ch][bb3_pkg::NUM_W-2:0], ge};
			end
		end
	end

	logic        out_valid_q;
	logic [23:0] out_data_q;
	logic        out_last_q;
	logic        out_fe_q;

	assign stat.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {num_q[2][7:0], num_q[1][7:0], num_q[0][7:0]};
			out_last_q <= cmd.run_last;
			out_fe_q   <= cmd.frame_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_fe_q;

endmodule

// ===== src/bb3_ctrl.sv =====
module bb3_ctrl #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [10:0]                  image_width,
	input  logic [15:0]                  image_height,
	input  logic                         restart,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	output bb3_pkg::dp_cmd_t             cmd,
	output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  bb3_pkg::dp_stat_t            stat
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = AW + 1;

	bb3_pkg::state_t state_q, state_d;

	logic [CW-1:0] w_e, wm1, cc;
	logic [15:0]   h_e;
	logic [AW-1:0] col_q, col_e;
	logic [15:0]   row_q, row_e;
	logic [1:0]    sel_q;
	logic          accept, at_end, last_row, col_nz;
	logic [3:0]    jobs_new;

	always_comb begin
		if (image_width == '0) begin
			w_e = CW'(1);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w_e = CW'(MAX_WIDTH);
		end else begin
			w_e = CW'(image_width);
		end
	end

	assign h_e = (image_height == '0) ? 16'd1 : image_height;
	assign wm1 = w_e - CW'(1);

	always_comb begin
		if (({1'b0, col_q} < w_e) && (row_q < h_e)) begin
			col_e = col_q;
			row_e = row_q;
		end else begin
			col_e = '0;
			row_e = '0;
		end
	end

	assign accept   = s_tvalid && s_tready;
	assign at_end   = {1'b0, col_e} == wm1;
	assign last_row = row_e == (h_e - 16'd1);
	assign col_nz   = col_e != '0;
	// order: previous row (col-1, last col), then last row (col-1, last col)
	assign jobs_new = {last_row && at_end, last_row && col_nz,
		(row_e != '0) && at_end, (row_e != '0) && col_nz};

	logic [3:0]    jobs_q, jpick_q;
	logic [AW-1:0] jcol_q, jc_q;
	logic          jrow1_q, jrow2_q;
	logic [1:0]    jsel_q;
	logic [2:0]    jmask_q;
	logic          jfe_q, jrl_q;
	logic [1:0]    k_q;
	logic [3:0]    div_q;

	logic [3:0]    pick_oh;
	logic [AW-1:0] pick_c;
	logic [2:0]    pick_mask;
	logic [1:0]    mid_b, old_b;

	always_comb begin
		if (jobs_q[0]) begin
			pick_oh = 4'b0001;
		end else if (jobs_q[1]) begin
			pick_oh = 4'b0010;
		end else if (jobs_q[2]) begin
			pick_oh = 4'b0100;
		end else begin
			pick_oh = 4'b1000;
		end
		pick_c = (pick_oh[0] || pick_oh[2]) ? jcol_q - AW'(1) : wm1[AW-1:0];
		mid_b  = (jsel_q == 2'd0) ? 2'd2 : jsel_q - 2'd1;
		old_b  = (jsel_q == 2'd2) ? 2'd0 : jsel_q + 2'd1;
		pick_mask = 3'b001 << jsel_q;
		if (jrow1_q) begin
			pick_mask = pick_mask | (3'b001 << mid_b);
		end
		if ((pick_oh[0] || pick_oh[1]) && jrow2_q) begin
			pick_mask = pick_mask | (3'b001 << old_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bb3_pkg::ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			sel_q   <= '0;
			jobs_q  <= '0;
			jpick_q <= '0;
			k_q     <= '0;
			div_q   <= '0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (at_end) begin
					col_q <= '0;
					row_q <= last_row ? 16'd0 : row_e + 16'd1;
					sel_q <= (sel_q == 2'd2) ? 2'd0 : sel_q + 2'd1;
				end else begin
					col_q <= col_e + AW'(1);
					row_q <= row_e;
				end
			end
			if (accept) begin
				jobs_q <= jobs_new;
			end else if (state_q == bb3_pkg::ST_OUT && stat.out_free) begin
				jobs_q <= jobs_q & ~jpick_q;
			end
			if (state_q == bb3_pkg::ST_START) begin
				jpick_q <= pick_oh;
				k_q     <= '0;
			end else if (state_q == bb3_pkg::ST_READ) begin
				k_q <= k_q + 2'd1;
			end
			if (state_q == bb3_pkg::ST_DLOAD) begin
				div_q <= '0;
			end else if (state_q == bb3_pkg::ST_DIV) begin
				div_q <= div_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			jcol_q  <= col_e;
			jrow1_q <= row_e != '0;
			jrow2_q <= row_e > 16'd1;
			jsel_q  <= sel_q;
		end
		if (state_q == bb3_pkg::ST_START) begin
			jc_q    <= pick_c;
			jmask_q <= pick_mask;
			jfe_q   <= pick_oh[3];
			jrl_q   <= (jobs_q & ~pick_oh) == '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bb3_pkg::ST_IDLE: begin
				if (accept && (jobs_new != '0)) begin
					state_d = bb3_pkg::ST_START;
				end
			end
			bb3_pkg::ST_START: state_d = bb3_pkg::ST_READ;
			bb3_pkg::ST_READ: begin
				if (k_q == 2'd2) begin
					state_d = bb3_pkg::ST_DRAIN;
				end
			end
			bb3_pkg::ST_DRAIN: state_d = bb3_pkg::ST_DLOAD;
			bb3_pkg::ST_DLOAD: state_d = bb3_pkg::ST_DIV;
			bb3_pkg::ST_DIV: begin
				if (div_q == 4'(bb3_pkg::DIV_STEPS - 1)) begin
					state_d = bb3_pkg::ST_OUT;
				end
			end
			bb3_pkg::ST_OUT: begin
				if (stat.out_free) begin
					state_d = ((jobs_q & ~jpick_q) != '0) ? bb3_pkg::ST_START
						: bb3_pkg::ST_IDLE;
				end
			end
			default: state_d = bb3_pkg::ST_IDLE;
		endcase
	end

	// column of this read; wraps high for col -1, so one compare covers both edges
	assign cc      = {1'b0, jc_q} + CW'(k_q) - CW'(1);
	assign rd_addr = cc[AW-1:0];
	assign wr_addr = col_e;

	always_comb begin
		s_tready      = 1'b0;
		cmd           = '0;
		cmd.wr_en     = accept;
		cmd.wr_bank   = sel_q;
		cmd.bank_mask = jmask_q;
		cmd.run_last  = jrl_q;
		cmd.frame_end = jfe_q;
		unique case (state_q)
			bb3_pkg::ST_IDLE:  s_tready = 1'b1;
			bb3_pkg::ST_START: cmd.acc_clr = 1'b1;
			bb3_pkg::ST_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.col_ok = cc < w_e;
			end
			bb3_pkg::ST_DRAIN: ;
			bb3_pkg::ST_DLOAD: cmd.div_load = 1'b1;
			bb3_pkg::ST_DIV:   cmd.div_step = 1'b1;
			bb3_pkg::ST_OUT:   cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

endmodule

// ===== src/box_blur_3x3_edge_aware.sv =====
// 3x3 box blur for RGB frames, averaging only neighbors inside the frame.
// Input stream s_*: one pixel per request in raster order. Output stream
// m_*: blurred pixels; the result for pixel (r,c) is released by input
// (r+1,c+1), and at row ends and in the last row one input releases up to
// four results. m_tlast marks the last result released by an input,
// m_tuser marks the frame's bottom-right pixel.
// Sequence: an input is taken while idle; each result it releases then
// takes a start, 3 column reads of the three row memories, one drain,
// a 13-step restoring divide and an output load. s_tready is high only
// while idle; the last result may still sit in the output register
// while the next input is taken. A stalled m_tready holds the output
// register and the sequencer waits before loading the next result.
// APB: register 0 (image_width) at 0x0, register 1 (image_height) at 0x4;
// a write restarts the frame at row 0, column 0. Reset gives 640x480,
// frame position zero, empty output; row memories are not cleared.
module box_blur_3x3_edge_aware #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
	output logic        m_tlast,
	output logic        m_tuser,   // frame_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic [10:0] width_q;
	logic [15:0] height_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? {16'd0, height_q} : {21'd0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 16'd480;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				height_q <= pwdata[15:0];
			end else begin
				width_q <= pwdata[10:0];
			end
		end
	end

	bb3_pkg::dp_cmd_t  cmd;
	bb3_pkg::dp_stat_t stat;
	logic [AW-1:0]     wr_addr, rd_addr;

	bb3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (width_q),
		.image_height (height_q),
		.restart      (cfg_wr),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr),
		.stat         (stat)
	);

	bb3_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.pix_in   (s_tdata),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
